// ===== rtl/vwar_pkg.sv =====
// Shared types, codes and text constants of the voltage window ASCII reporter.
package vwar_pkg;

  localparam int THR_W  = 12;
  localparam int CFG_AW = 8;
  localparam int CFG_DW = 16;
  localparam int OUT_W  = 16;

  localparam logic [CFG_AW-1:0] REG_OVER_THR  = 8'd0;
  localparam logic [CFG_AW-1:0] REG_UNDER_THR = 8'd1;

  localparam logic [THR_W-1:0] OVER_THR_RST  = 12'd3661;
  localparam logic [THR_W-1:0] UNDER_THR_RST = 12'd3201;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [2:0] LED_RED   = 3'b001;
  localparam logic [2:0] LED_BLUE  = 3'b010;
  localparam logic [2:0] LED_GREEN = 3'b100;

  localparam int TXT_OVER_LEN   = 22;
  localparam int TXT_UNDER_LEN  = 23;
  localparam int TXT_NORMAL_LEN = 16;

  localparam logic [8*TXT_OVER_LEN-1:0]   TXT_OVER   = "Overvoltage Detected: ";
  localparam logic [8*TXT_UNDER_LEN-1:0]  TXT_UNDER  = "Undervoltage Detected: ";
  localparam logic [8*TXT_NORMAL_LEN-1:0] TXT_NORMAL = "Voltage Normal: ";

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_OVER   = 2'd1,
    ST_UNDER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_TEXT,
    RS_CR1,
    RS_LF1,
    RS_DIGIT,
    RS_CR2,
    RS_LF2
  } rpt_state_t;

  function automatic logic [4:0] txt_len(status_t st);
    logic [4:0] n;
    case (st)
      ST_OVER:  n = 5'(TXT_OVER_LEN);
      ST_UNDER: n = 5'(TXT_UNDER_LEN);
      default:  n = 5'(TXT_NORMAL_LEN);
    endcase
    return n;
  endfunction

  // The first character of a string literal sits in the highest byte.
  function automatic logic [7:0] txt_byte(status_t st, logic [4:0] idx);
    logic [7:0] b;
    int i;
    i = int'(idx);
    case (st)
      ST_OVER: begin
        b = (i < TXT_OVER_LEN) ? TXT_OVER[8*(TXT_OVER_LEN-1-i) +: 8] : CH_CR;
      end
      ST_UNDER: begin
        b = (i < TXT_UNDER_LEN) ? TXT_UNDER[8*(TXT_UNDER_LEN-1-i) +: 8] : CH_CR;
      end
      default: begin
        b = (i < TXT_NORMAL_LEN) ? TXT_NORMAL[8*(TXT_NORMAL_LEN-1-i) +: 8] : CH_CR;
      end
    endcase
    return b;
  endfunction

  function automatic logic [2:0] led_of(status_t st);
    logic [2:0] l;
    case (st)
      ST_OVER:  l = LED_GREEN;
      ST_UNDER: l = LED_RED;
      default:  l = LED_BLUE;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/voltage_window_ascii_reporter.sv =====
// Voltage window classifier that streams an ASCII status report per sample.
//
// Usage:
//   in_*  : one sample per transfer, in_tdata[SAMPLE_BITS-1:0], upper bits ignored.
//   out_* : one report byte per transfer; out_tlast marks the closing LF.
//   cfg_* : register writes (0 over threshold, 1 under threshold), always ready.
//           Write the thresholds only while no report is in flight.
//   A report is the status text, CR LF, the sample in decimal without
//   leading zeros, CR LF: 21 to 31 bytes.
// Throughput: one report byte per cycle while out_tready is high and the
//   converter has the digits ready; the next sample is taken in idle. The
//   decimal digits come from a bit-serial double-dabble converter (a shift
//   per sample bit, then the leading zero digits are dropped) that runs
//   while the text goes out; at wide samples the first digit can wait on it.
// A new sample is taken once the last byte of the report sits in the output
//   register, even if the receiver has not taken it yet.
// Reset (rst_n low at a clock edge) drops any report in progress and restores
//   the default thresholds. When out_tready is low, the output byte holds and
//   the report pauses.
module voltage_window_ascii_reporter #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: status[1:0], leds[4:2], tx_byte[12:5], zero fill
  output logic [vwar_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vwar_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [vwar_pkg::CFG_DW-1:0]       cfg_data
);
  import vwar_pkg::*;

  localparam int NDIG = (SAMPLE_BITS * 301 + 999) / 1000;
  localparam int CW   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int BCW  = $clog2(SAMPLE_BITS + 1);
  localparam int DCW  = $clog2(NDIG + 1);

  logic [THR_W-1:0]       over_thr_r;
  logic [THR_W-1:0]       under_thr_r;

  rpt_state_t             state_r, state_nxt;
  logic [4:0]             txt_idx_r, txt_idx_nxt;
  status_t                status_r;

  logic [SAMPLE_BITS-1:0] bin_r;
  logic [4*NDIG-1:0]      bcd_r;
  logic [4*NDIG-1:0]      bcd_adj;
  logic [BCW-1:0]         bit_left_r;
  logic [DCW-1:0]         dig_left_r;
  logic                   cvt_done_r;
  logic [3:0]             top_dig;

  logic                   out_valid_r;
  logic                   out_last_r;
  logic [7:0]             out_byte_r;
  logic [2:0]             out_leds_r;
  status_t                out_status_r;

  logic                   in_acc;
  logic                   out_free;
  logic                   ld;
  logic                   last_sel;
  logic [7:0]             byte_sel;
  logic                   dig_emit;
  logic [SAMPLE_BITS-1:0] smp;
  logic [CW-1:0]          smp_ext;
  status_t                status_new;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == RS_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign top_dig   = bcd_r[4*NDIG-1 -: 4];
  assign dig_emit  = ld && (state_r == RS_DIGIT);

  assign smp     = in_tdata[SAMPLE_BITS-1:0];
  assign smp_ext = CW'(smp);

  always_comb begin
    if (smp_ext > CW'(over_thr_r)) begin
      status_new = ST_OVER;
    end else if (smp_ext < CW'(under_thr_r)) begin
      status_new = ST_UNDER;
    end else begin
      status_new = ST_NORMAL;
    end
  end

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      over_thr_r  <= OVER_THR_RST;
      under_thr_r <= UNDER_THR_RST;
    end else if (cfg_valid) begin
      if (cfg_addr == REG_OVER_THR) begin
        over_thr_r <= cfg_data[THR_W-1:0];
      end else if (cfg_addr == REG_UNDER_THR) begin
        under_thr_r <= cfg_data[THR_W-1:0];
      end
    end
  end

  // Add-3 correction of every BCD digit before the next shift.
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                      : bcd_r[4*d +: 4];
    end
  end

  // Bit-serial binary to BCD, then drop leading zero digits one per cycle.
  // The digit emitter shifts the same register as digits go out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_left_r <= '0;
      dig_left_r <= '0;
      cvt_done_r <= 1'b1;
    end else if (in_acc) begin
      bin_r      <= smp;
      bcd_r      <= '0;
      bit_left_r <= BCW'(SAMPLE_BITS);
      dig_left_r <= DCW'(NDIG);
      cvt_done_r <= 1'b0;
    end else if (bit_left_r != '0) begin
      bcd_r      <= {bcd_adj[4*NDIG-2:0], bin_r[SAMPLE_BITS-1]};
      bin_r      <= {bin_r[SAMPLE_BITS-2:0], 1'b0};
      bit_left_r <= bit_left_r - 1'b1;
    end else if (!cvt_done_r) begin
      if (dig_left_r > DCW'(1) && top_dig == 4'd0) begin
        bcd_r      <= {bcd_r[4*NDIG-5:0], 4'd0};
        dig_left_r <= dig_left_r - 1'b1;
      end else begin
        cvt_done_r <= 1'b1;
      end
    end else if (dig_emit) begin
      bcd_r      <= {bcd_r[4*NDIG-5:0], 4'd0};
      dig_left_r <= dig_left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= RS_IDLE;
      txt_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      txt_idx_r <= txt_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_new;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    txt_idx_nxt = txt_idx_r;
    ld          = 1'b0;
    byte_sel    = CH_CR;
    last_sel    = 1'b0;
    case (state_r)
      RS_IDLE: begin
        if (in_acc) begin
          state_nxt   = RS_TEXT;
          txt_idx_nxt = '0;
        end
      end
      RS_TEXT: begin
        byte_sel = txt_byte(status_r, txt_idx_r);
        if (out_free) begin
          ld = 1'b1;
          if (txt_idx_r == txt_len(status_r) - 5'd1) begin
            state_nxt = RS_CR1;
          end else begin
            txt_idx_nxt = txt_idx_r + 5'd1;
          end
        end
      end
      RS_CR1: begin
        byte_sel = CH_CR;
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = RS_LF1;
        end
      end
      RS_LF1: begin
        byte_sel = CH_LF;
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = RS_DIGIT;
        end
      end
      RS_DIGIT: begin
        byte_sel = CH_ZERO | {4'd0, top_dig};
        if (out_free && cvt_done_r) begin
          ld = 1'b1;
          if (dig_left_r == DCW'(1)) begin
            state_nxt = RS_CR2;
          end
        end
      end
      RS_CR2: begin
        byte_sel = CH_CR;
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = RS_LF2;
        end
      end
      RS_LF2: begin
        byte_sel = CH_LF;
        last_sel = 1'b1;
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = RS_IDLE;
        end
      end
      default: begin
        state_nxt = RS_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte_r   <= byte_sel;
      out_last_r   <= last_sel;
      out_status_r <= status_r;
      out_leds_r   <= led_of(status_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'd0, out_byte_r, out_leds_r, out_status_r};

`ifndef NO_ASSERTIONS
  // Every digit has gone out before the closing CR.
  a_digits_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RS_CR2) |-> (dig_left_r == '0))
    else $error("report left the digit phase with digits pending");

  // A sample transfer restarts the converter and the text phase together.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == RS_TEXT) && !cvt_done_r && (txt_idx_r == '0))
    else $error("sample transfer did not start a report");

  // The LED drive of a valid byte is one-hot and matches its status.
  a_leds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_leds_r) && (out_leds_r == led_of(out_status_r)))
    else $error("LED drive does not match status");

  // The flagged byte is always the final LF.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_byte_r == CH_LF) && (state_r != RS_DIGIT))
    else $error("last flag on a byte other than the closing LF");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the voltage window ASCII reporter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vwar_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 58;

  localparam logic [CFG_AW-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_AW-1:0] REG_TOP   = 8'hFF;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] leds;
    logic [7:0] chr;
    logic       last;
  } report_byte_t;

  // Predicts the byte stream of each report and checks the bytes that come out.
  class report_checker;
    report_byte_t     expected_bytes[$];
    logic [THR_W-1:0] over_thr;
    logic [THR_W-1:0] under_thr;
    int               errors;

    function new();
      over_thr  = OVER_THR_RST;
      under_thr = UNDER_THR_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      if (addr == REG_OVER_THR)
        over_thr = data[THR_W-1:0];
      else if (addr == REG_UNDER_THR)
        under_thr = data[THR_W-1:0];
    endfunction

    function void push(status_t st, logic [2:0] led, logic [7:0] chr, logic last);
      report_byte_t b;
      b.status = st;
      b.leds   = led;
      b.chr    = chr;
      b.last   = last;
      expected_bytes.push_back(b);
    endfunction

    function void predict_report(logic [IN_W-1:0] word);
      logic [SAMPLE_BITS-1:0] smp;
      status_t    st;
      logic [2:0] led;
      string      txt;
      logic [7:0] digs[8];
      int         nd;
      int         v;
      smp = word[SAMPLE_BITS-1:0];
      // The over test comes first, so it wins when the thresholds are crossed.
      if (smp > over_thr) begin
        st = ST_OVER;
        led = LED_GREEN;
        txt = "Overvoltage Detected: ";
      end else if (smp < under_thr) begin
        st = ST_UNDER;
        led = LED_RED;
        txt = "Undervoltage Detected: ";
      end else begin
        st = ST_NORMAL;
        led = LED_BLUE;
        txt = "Voltage Normal: ";
      end
      for (int i = 0; i < txt.len(); i++)
        push(st, led, txt[i], 1'b0);
      push(st, led, CH_CR, 1'b0);
      push(st, led, CH_LF, 1'b0);
      v = int'(smp);
      nd = 0;
      do begin
        digs[nd] = CH_ZERO + 8'(v % 10);
        nd++;
        v = v / 10;
      end while (v != 0 && nd < 8);
      while (nd > 0) begin
        nd--;
        push(st, led, digs[nd], 1'b0);
      end
      push(st, led, CH_CR, 1'b0);
      push(st, led, CH_LF, 1'b1);
    endfunction

    task flag(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] data, logic last);
      report_byte_t exp;
      if (expected_bytes.size() == 0) begin
        flag($sformatf("byte 0x%02h arrived with no report pending", data[12:5]));
        return;
      end
      exp = expected_bytes.pop_front();
      if (data[1:0] !== exp.status || data[4:2] !== exp.leds || data[12:5] !== exp.chr ||
          data[OUT_W-1:13] !== '0 || last !== exp.last)
        flag($sformatf("got st/led/byte/fill/last %0d/%b/%02h/%b/%b, want %0d/%b/%02h/%b",
                       data[1:0], data[4:2], data[12:5], data[OUT_W-1:13], last,
                       exp.status, exp.leds, exp.chr, exp.last));
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tlast;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_AW-1:0]   cfg_addr = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;

  report_checker sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  voltage_window_ascii_reporter #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: checks each byte transfer and decides the next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast);
    out_tready <= (int'($urandom_range(99)) >= stall_pct);
  end

  task set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        gap_pct = 59;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct = 59;
      end
      IDLE_BOTH: begin
        gap_pct = 38;
        stall_pct = 38;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // Leaves in_tvalid high after the transfer so back-to-back samples need no gap.
  task send_sample(logic [IN_W-1:0] word);
    while (int'($urandom_range(99)) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sb.predict_report(word);
  endtask

  task stop_samples();
    in_tvalid <= 1'b0;
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(addr, data);
  endtask

  function automatic logic [IN_W-1:0] pick_sample();
    logic [IN_W-1:0] w;
    int base;
    w = IN_W'($urandom);
    case ($urandom_range(9))
      0, 1: base = int'(sb.over_thr) + int'($urandom_range(6)) - 3;
      2, 3: base = int'(sb.under_thr) + int'($urandom_range(6)) - 3;
      4: base = int'($urandom_range(120));
      5: base = ($urandom_range(1) == 0) ? int'($urandom_range(1)) :
                SAMPLE_MAX - int'($urandom_range(1));
      default: base = int'($urandom_range(SAMPLE_MAX));
    endcase
    if (base < 0) base = 0;
    if (base > SAMPLE_MAX) base = SAMPLE_MAX;
    w[SAMPLE_BITS-1:0] = SAMPLE_BITS'(base);
    return w;
  endfunction

  task run_phase(idle_mode_t mode, int over, int under);
    set_idle(mode);
    // Upper data bits are random; only the low threshold bits should stick.
    write_reg(REG_OVER_THR, {4'($urandom), THR_W'(over)});
    write_reg(REG_UNDER_THR, {4'($urandom), THR_W'(under)});
    if ($urandom_range(1) == 0)
      write_reg(REG_SPARE, CFG_DW'($urandom));
    for (int i = 0; i < PHASE_ITEMS; i++)
      send_sample(pick_sample());
    stop_samples();
  endtask

  initial begin
    int ovr;
    int und;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Writes to unknown registers must leave the default window in place.
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_TOP, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0E4D);
    send_sample(16'hAE4E);
    send_sample(16'h0C81);
    send_sample(16'h5C80);
    send_sample(16'h0009);
    send_sample(16'h000A);
    send_sample(16'h0064);
    send_sample(16'h03E8);
    stop_samples();

    // Crossed window: under above over, the over test still wins.
    write_reg(REG_OVER_THR, 16'hF064);
    write_reg(REG_UNDER_THR, 16'h07D0);
    send_sample(16'h0032);
    send_sample(16'h0096);
    send_sample(16'h0064);
    stop_samples();

    write_reg(REG_OVER_THR, 16'h0000);
    write_reg(REG_UNDER_THR, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    stop_samples();

    write_reg(REG_OVER_THR, 16'h0FFF);
    write_reg(REG_UNDER_THR, 16'hFFFF);
    send_sample(16'h0FFE);
    send_sample(16'h0FFF);
    stop_samples();

    for (int p = 0; p < 8; p++) begin
      ovr = int'($urandom_range(SAMPLE_MAX));
      und = int'($urandom_range(SAMPLE_MAX));
      case (p)
        0: begin
          ovr = int'(OVER_THR_RST);
          und = int'(UNDER_THR_RST);
        end
        1: begin
          if (ovr < und) begin
            ovr = ovr + und;
            und = ovr - und;
            ovr = ovr - und;
          end
        end
        2: begin
          if (ovr > und) begin
            ovr = ovr + und;
            und = ovr - und;
            ovr = ovr - und;
          end
        end
        3: begin
          ovr = SAMPLE_MAX;
          und = 0;
        end
        4: begin
          ovr = 0;
          und = SAMPLE_MAX;
        end
        6: begin
          ovr = 0;
          und = 0;
        end
        7: begin
          ovr = SAMPLE_MAX;
          und = SAMPLE_MAX;
        end
        default: ;
      endcase
      run_phase(idle_mode_t'(p % 4), ovr, und);
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
